### rtl/core/bilinear_upscale_8x_wrap_defines.svh
// Assertion macros for the bilinear 8x upscaler.
// Used by bilinear_upscale_8x_wrap; needs nothing else.
`ifndef BILINEAR_UPSCALE_8X_WRAP_DEFINES_SVH
`define BILINEAR_UPSCALE_8X_WRAP_DEFINES_SVH

// Same-cycle implication.
`define BLU8_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BLU8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/blu8_pkg.sv
// Shared types and constants of the bilinear 8x upscaler.
// Used by every module of the block; depends on nothing.
package blu8_pkg;

  localparam int LOW_DIM   = 256;
  localparam int HIGH_DIM  = 2048;
  localparam int LOW_BITS  = $clog2(LOW_DIM);
  localparam int HIGH_BITS = $clog2(HIGH_DIM);
  localparam int FRAC_BITS = 3;
  localparam int ADDR_BITS = 2 * LOW_BITS;
  localparam int IDX_BITS  = 23;
  localparam int SUM_BITS  = 18;
  localparam int VAL_BITS  = 8;
  localparam int APB_ABITS = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_PAIR_MODE = 1'b0;

  typedef struct packed {
    logic                 cmd;
    logic [LOW_BITS-1:0]  low_x;
    logic [LOW_BITS-1:0]  low_y;
    logic [VAL_BITS-1:0]  sample;
    logic [HIGH_BITS-1:0] high_x;
    logic [HIGH_BITS-1:0] high_y;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] out_index;
    logic [VAL_BITS-1:0] out_value;
    logic                last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAIR,
    ST_CALC
  } fsm_state_t;

  typedef struct packed {
    logic                 fire;
    logic [HIGH_BITS-1:0] hx;
    logic [HIGH_BITS-1:0] hy;
    logic [VAL_BITS-1:0]  a;
    logic [VAL_BITS-1:0]  b;
    logic [VAL_BITS-1:0]  c;
    logic [VAL_BITS-1:0]  d;
  } op_t;

endpackage

### rtl/core/blu8_map.sv
// Low-resolution height map: one write port, two registered read ports.
// Depends on blu8_pkg.
module blu8_map (
  input  logic                           clk,
  input  logic                           wen,
  input  logic [blu8_pkg::ADDR_BITS-1:0] waddr,
  input  logic [blu8_pkg::VAL_BITS-1:0]  wdata,
  input  logic                           ren,
  input  logic [blu8_pkg::ADDR_BITS-1:0] raddr0,
  input  logic [blu8_pkg::ADDR_BITS-1:0] raddr1,
  output logic [blu8_pkg::VAL_BITS-1:0]  rdata0,
  output logic [blu8_pkg::VAL_BITS-1:0]  rdata1
);

  logic [blu8_pkg::VAL_BITS-1:0] mem [blu8_pkg::LOW_DIM * blu8_pkg::LOW_DIM];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### rtl/core/blu8_fetch.sv
// Request sequencer: stores samples, fetches the four corners of a query.
// Depends on blu8_pkg and blu8_map.
module blu8_fetch (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  blu8_pkg::req_t     req,
  input  logic               out_free,
  output blu8_pkg::op_t      op
);

  blu8_pkg::fsm_state_t state, state_next;

  logic [blu8_pkg::HIGH_BITS-1:0] hx, hy;
  logic [blu8_pkg::VAL_BITS-1:0]  a_q, b_q;
  logic [blu8_pkg::VAL_BITS-1:0]  rd0, rd1;
  logic                           accept, wen, ren, fire;
  logic [blu8_pkg::LOW_BITS-1:0]  x0, y0, x1, y1;
  logic [blu8_pkg::ADDR_BITS-1:0] raddr0, raddr1;

  assign accept = req_valid && !req_stall;
  assign wen    = accept && (req.cmd == blu8_pkg::CMD_WRITE);

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    ren        = 1'b0;
    fire       = 1'b0;
    x0 = hx[blu8_pkg::HIGH_BITS-1:blu8_pkg::FRAC_BITS];
    y0 = hy[blu8_pkg::HIGH_BITS-1:blu8_pkg::FRAC_BITS];
    case (state)
      blu8_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        x0 = req.high_x[blu8_pkg::HIGH_BITS-1:blu8_pkg::FRAC_BITS];
        y0 = req.high_y[blu8_pkg::HIGH_BITS-1:blu8_pkg::FRAC_BITS];
        if (req_valid && (req.cmd == blu8_pkg::CMD_QUERY)) begin
          ren        = 1'b1;
          state_next = blu8_pkg::ST_PAIR;
        end
      end
      blu8_pkg::ST_PAIR: begin
        ren        = 1'b1;
        state_next = blu8_pkg::ST_CALC;
      end
      blu8_pkg::ST_CALC: begin
        if (out_free) begin
          fire       = 1'b1;
          state_next = blu8_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = blu8_pkg::ST_IDLE;
      end
    endcase
    x1 = x0 + 1'b1;
    y1 = y0 + 1'b1;
    if (state == blu8_pkg::ST_PAIR) begin
      raddr0 = {y1, x0};
      raddr1 = {y1, x1};
    end else begin
      raddr0 = {y0, x0};
      raddr1 = {y0, x1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blu8_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hx <= req.high_x;
      hy <= req.high_y;
    end
    if (state == blu8_pkg::ST_PAIR) begin
      a_q <= rd0;
      b_q <= rd1;
    end
  end

  blu8_map u_map (
    .clk    (clk),
    .wen    (wen),
    .waddr  ({req.low_y, req.low_x}),
    .wdata  (req.sample),
    .ren    (ren),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  assign op.fire = fire;
  assign op.hx   = hx;
  assign op.hy   = hy;
  assign op.a    = a_q;
  assign op.b    = b_q;
  assign op.c    = rd0;
  assign op.d    = rd1;

endmodule

### rtl/core/blu8_out.sv
// Bilinear arithmetic and the result register, with the spread pair.
// Depends on blu8_pkg.
module blu8_out (
  input  logic           clk,
  input  logic           rst,
  input  blu8_pkg::op_t  op,
  input  logic           pair_mode,
  output logic           out_free,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output blu8_pkg::rsp_t rsp
);

  logic [blu8_pkg::FRAC_BITS-1:0] fx, fy;
  logic signed [blu8_pkg::SUM_BITS-1:0] a_s, b_s, c_s, d_s;
  logic signed [blu8_pkg::SUM_BITS-1:0] fx_s, fy_s, fxy_s;
  logic signed [blu8_pkg::SUM_BITS-1:0] dx, dy, dxy, sum, q;
  logic [blu8_pkg::VAL_BITS-1:0]        value;
  logic [blu8_pkg::IDX_BITS-2:0]        pix;

  assign fx = op.hx[blu8_pkg::FRAC_BITS-1:0];
  assign fy = op.hy[blu8_pkg::FRAC_BITS-1:0];

  always_comb begin
    a_s   = {{(blu8_pkg::SUM_BITS-blu8_pkg::VAL_BITS){1'b0}}, op.a};
    b_s   = {{(blu8_pkg::SUM_BITS-blu8_pkg::VAL_BITS){1'b0}}, op.b};
    c_s   = {{(blu8_pkg::SUM_BITS-blu8_pkg::VAL_BITS){1'b0}}, op.c};
    d_s   = {{(blu8_pkg::SUM_BITS-blu8_pkg::VAL_BITS){1'b0}}, op.d};
    fx_s  = {{(blu8_pkg::SUM_BITS-blu8_pkg::FRAC_BITS){1'b0}}, fx};
    fy_s  = {{(blu8_pkg::SUM_BITS-blu8_pkg::FRAC_BITS){1'b0}}, fy};
    fxy_s = fx_s * fy_s;
    dx    = b_s - a_s;
    dy    = c_s - a_s;
    dxy   = d_s - b_s - c_s + a_s;
    sum   = ((dx * fx_s) <<< blu8_pkg::FRAC_BITS)
          + ((dy * fy_s) <<< blu8_pkg::FRAC_BITS)
          + (dxy * fxy_s);
    q     = sum >>> (2 * blu8_pkg::FRAC_BITS);
    value = op.a + q[blu8_pkg::VAL_BITS-1:0];
    pix   = {op.hy, op.hx};
  end

  assign out_free = !rsp_valid || (!rsp_stall && rsp.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (op.fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall && rsp.last) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.fire) begin
      rsp.out_value <= value;
      if (pair_mode) begin
        rsp.out_index <= {pix, 1'b0};
        rsp.last      <= 1'b0;
      end else begin
        rsp.out_index <= {1'b0, pix};
        rsp.last      <= 1'b1;
      end
    end else if (rsp_valid && !rsp_stall && !rsp.last) begin
      rsp.out_index[0] <= 1'b1;
      rsp.last         <= 1'b1;
    end
  end

endmodule

### rtl/core/bilinear_upscale_8x_wrap.sv
// Top level of the bilinear 8x upscaler with a wrapping low-res map.
// Depends on blu8_pkg, blu8_fetch, blu8_out and the assertion macro header.
//
// Usage:
//   Requests enter on req_valid/req_stall/req. A write request (cmd = write)
//   stores one sample into the 256x256 map and produces no response. A query
//   request (cmd = query) produces one response on rsp_valid/rsp_stall/rsp,
//   or two when pair_mode is set (indices 2p and 2p+1, last on the second).
//   A query occupies the sequencer from acceptance through ST_PAIR and
//   ST_CALC: the accept and ST_PAIR each issue one paired map read (two read
//   ports, two corners per read), and ST_CALC does the arithmetic into the
//   result register. A new request is taken the cycle after the result is
//   loaded; no new request is taken while a query is in progress.
//   When the receiver stalls, the result register holds and the sequencer
//   waits in its arithmetic cycle; requests stall until the result moves.
//   Reset clears the control state and pair_mode; the map is not
//   cleared, and a query may only touch samples that were written.
//   pair_mode is written over the APB port at address 0 (only paddr[2] decoded).
`include "bilinear_upscale_8x_wrap_defines.svh"

module bilinear_upscale_8x_wrap (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  blu8_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output blu8_pkg::rsp_t                 rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [blu8_pkg::APB_ABITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic          pair_mode;
  logic          out_free;
  blu8_pkg::op_t op;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == blu8_pkg::REG_PAIR_MODE)) begin
      pair_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == blu8_pkg::REG_PAIR_MODE) begin
      prdata[0] = pair_mode;
    end
  end

  blu8_fetch u_fetch (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .out_free  (out_free),
    .op        (op)
  );

  blu8_out u_out (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .pair_mode (pair_mode),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `BLU8_ASSERT_NEXT(a_pair_second, clk, rst, rsp_valid && !rsp_stall && !rsp.last, rsp_valid && rsp.last, "second spread response missing")
  `BLU8_ASSERT_NOW(a_pair_even, clk, rst, rsp_valid && !rsp.last, rsp.out_index[0] == 1'b0, "first spread response has odd index")
  `BLU8_ASSERT_NEXT(a_query_busy, clk, rst, req_valid && !req_stall && (req.cmd == blu8_pkg::CMD_QUERY), req_stall, "sequencer took a request during a fetch")

endmodule
